### rtl/ssmm_pkg.sv
// Package for the set sum, mean and median block: sizes, state codes and
// the divider status type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssmm_pkg;

    localparam int MAX_ITEMS   = 256;
    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = 16;
    localparam int SUM_W       = 24;
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W       = $clog2(MAX_ITEMS);
    localparam int DIVD_W      = SUM_W + 8;
    localparam int DCNT_W      = $clog2(DIVD_W + 1);
    localparam int MEAN_W      = 24;
    localparam int MED_W       = 17;
    localparam int OUT_CNT_W   = 9;
    localparam int OUT_TDATA_W = 80;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

### rtl/set_sum_mean_median.sv
// Top level of the set sum, mean and median block: a chain of sorting
// cells, a running sum and count, and a serial divider for the mean.
// Depends on ssmm_pkg, ssmm_cell and ssmm_div.
//
// Channel   Direction  Width  Contents
// s_axis    in         16+1   tdata: sample; tlast: final_item
// m_axis    out        80     tdata: total_sum, mean_q8, median_times_two,
//                             item_count, overflowed, zero padding
//
// While a set is gathered the block takes one sample every cycle: each
// magnitude is inserted into ascending order across the cell chain in the
// cycle it is accepted. After the final sample the block stops accepting;
// the 32-step divider and the shift of the chain towards cell zero run in
// parallel, and the result is shown once both are through. The result
// waits in its register until it is taken, and the next set may start in
// the cycle after. Reset is synchronous and active low; it clears the
// control state only.
`timescale 1ns / 1ps
`default_nettype none

module set_sum_mean_median (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: [15:0] sample (signed)
    input  wire [ssmm_pkg::SAMPLE_W-1:0]       s_axis_tdata,
    // tlast: final_item
    input  wire                                s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // tdata: [23:0] total_sum, [47:24] mean_q8, [64:48] median_times_two,
    //        [73:65] item_count, [74] overflowed, [79:75] zero
    output logic [ssmm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import ssmm_pkg::*;

    // Control state.
    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_sum;
    logic             r_ovf;
    logic             r_med_done;

    // Result and drain bookkeeping (no reset needed).
    logic [CNT_W-1:0]  r_res_n;
    logic [SUM_W-1:0]  r_res_sum;
    logic              r_res_ovf;
    logic [CNT_W-1:0]  r_lo;
    logic [CNT_W-1:0]  r_hi;
    logic [CNT_W-1:0]  r_step;
    logic [MAG_W-1:0]  r_lo_val;
    logic [MAG_W-1:0]  r_hi_val;
    logic [MED_W-1:0]  r_med2;
    logic [MEAN_W-1:0] r_mean;

    logic [MAG_W-1:0]  mag;
    logic              accept;
    logic              full;
    logic              ins;
    logic              shift;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_sat;
    logic [SUM_W-1:0]  sum_fin;
    logic [CNT_W-1:0]  n_count;
    logic              div_start;
    logic [DIVD_W-1:0] div_quot;
    t_div_stat         div_stat;

    logic [MAG_W-1:0]  w_val [MAX_ITEMS];
    logic              w_gt  [MAX_ITEMS];

    // The most negative sample maps onto 0x8000, which still fits 16 bits.
    assign mag = s_axis_tdata[SAMPLE_W-1] ? MAG_W'(~s_axis_tdata + 1'b1)
                                          : MAG_W'(s_axis_tdata);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = (r_count == CNT_W'(MAX_ITEMS));
    assign ins           = accept && !full;
    assign shift         = (r_state == ST_RUN) && !r_med_done;

    // The running sum saturates rather than wrapping; only reachable with a
    // store of 512 entries or more.
    assign sum_add = {1'b0, r_sum} + (SUM_W + 1)'(mag);
    assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign sum_fin = ins ? sum_sat : r_sum;
    assign n_count = r_count + CNT_W'(ins);

    assign div_start = accept && s_axis_tlast;

    ssmm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({sum_fin, 8'd0}),
        .i_divisor  (n_count),
        .o_quot     (div_quot),
        .o_stat     (div_stat)
    );

    // The sorting chain. A cell counts as occupied when its place is below
    // the fill count; during the drain every cell but the last takes its
    // right-hand neighbour's value (the last keeps its own) so that the ordered set walks past cell zero.
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        localparam logic [CNT_W-1:0] CellIdx = CNT_W'(i);
        logic             occ;
        logic [MAG_W-1:0] left_val;
        logic             left_gt;
        logic [MAG_W-1:0] right_val;

        assign occ = CellIdx < r_count;

        if (i == 0) begin : g_first
            assign left_val = '0;
            assign left_gt  = 1'b0;
        end else begin : g_inner
            assign left_val = w_val[i-1];
            assign left_gt  = w_gt[i-1];
        end

        if (i == MAX_ITEMS - 1) begin : g_last
            assign right_val = w_val[i];
        end else begin : g_notlast
            assign right_val = w_val[i+1];
        end

        ssmm_cell u_cell (
            .i_clk       (i_clk),
            .i_ins       (ins),
            .i_shift     (shift),
            .i_occ       (occ),
            .i_mag       (mag),
            .i_left_val  (left_val),
            .i_left_gt   (left_gt),
            .i_right_val (right_val),
            .o_val       (w_val[i]),
            .o_gt        (w_gt[i])
        );
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_sum      <= '0;
            r_ovf      <= 1'b0;
            r_med_done <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_axis_tlast) begin
                            // The set closes: the running state is handed
                            // to the result side and cleared for the next.
                            r_count    <= '0;
                            r_sum      <= '0;
                            r_ovf      <= 1'b0;
                            r_med_done <= 1'b0;
                            r_state    <= ST_RUN;
                        end else begin
                            r_count <= n_count;
                            r_sum   <= sum_fin;
                            r_ovf   <= r_ovf || full;
                        end
                    end
                end
                ST_RUN: begin
                    if (!r_med_done && (r_step == r_hi)) begin
                        r_med_done <= 1'b1;
                    end
                    if (r_med_done && div_stat.done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (m_axis_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Result path. Cell zero shows the element at place r_step during the
    // drain; the two middle elements are caught as they pass.
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_res_n   <= n_count;
            r_res_sum <= sum_fin;
            r_res_ovf <= r_ovf || full;
            r_lo      <= (n_count - 1'b1) >> 1;
            r_hi      <= n_count >> 1;
            r_step    <= '0;
        end
        if (shift) begin
            if (r_step == r_lo) begin
                r_lo_val <= w_val[0];
            end
            if (r_step == r_hi) begin
                r_hi_val <= w_val[0];
            end
            r_step <= r_step + 1'b1;
        end
        if ((r_state == ST_RUN) && r_med_done && div_stat.done) begin
            // For an odd count both places coincide, giving twice the middle.
            r_med2 <= MED_W'(r_lo_val) + MED_W'(r_hi_val);
            r_mean <= div_quot[MEAN_W-1:0];
        end
    end

    assign m_axis_tvalid = (r_state == ST_DONE);
    assign m_axis_tdata  = {5'd0, r_res_ovf, OUT_CNT_W'(r_res_n), r_med2, r_mean, r_res_sum};

    // Assertions.
    localparam logic [CNT_W-1:0] FullCount = CNT_W'(MAX_ITEMS);

    // The fill count never exceeds the number of cells in the chain.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= FullCount))
        else $error("fill count beyond chain depth");

    // A result is never shown while a new sample can be taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("result shown while accepting samples");

    // Once a result is taken the block is ready for the next set.
    a_ready_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
        else $error("not ready after result");

    // Dropped samples only occur once the chain is full.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_res_ovf) |-> (r_res_n == FullCount))
        else $error("overflow flagged with room left");

endmodule

`default_nettype wire

### rtl/ssmm_cell.sv
// One cell of the sorting chain: holds one magnitude and either takes part
// in an ordered insertion or shifts towards cell zero. Depends on ssmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssmm_cell (
    input  wire                        i_clk,
    input  wire                        i_ins,
    input  wire                        i_shift,
    input  wire                        i_occ,
    input  wire [ssmm_pkg::MAG_W-1:0]  i_mag,
    input  wire [ssmm_pkg::MAG_W-1:0]  i_left_val,
    input  wire                        i_left_gt,
    input  wire [ssmm_pkg::MAG_W-1:0]  i_right_val,
    output logic [ssmm_pkg::MAG_W-1:0] o_val,
    output logic                       o_gt
);
    import ssmm_pkg::*;

    logic [MAG_W-1:0] r_val;
    logic [MAG_W-1:0] n_val;

    // An empty cell behaves as if it held a value above every magnitude.
    assign o_gt  = !i_occ || (r_val > i_mag);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ins && o_gt) begin
            n_val = i_left_gt ? i_left_val : i_mag;
        end else if (i_shift) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

### rtl/ssmm_div.sv
// Restoring divider, one quotient bit per cycle, for the mean.
// Depends on ssmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssmm_div (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire [ssmm_pkg::DIVD_W-1:0]  i_dividend,
    input  wire [ssmm_pkg::CNT_W-1:0]   i_divisor,
    output logic [ssmm_pkg::DIVD_W-1:0] o_quot,
    output ssmm_pkg::t_div_stat         o_stat
);
    import ssmm_pkg::*;

    logic [CNT_W:0]    r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_dvs;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [CNT_W:0]    rem_sh;
    logic              fits;

    assign rem_sh = {r_rem[CNT_W-1:0], r_quo[DIVD_W-1]};
    assign fits   = rem_sh >= {1'b0, r_dvs};
    assign o_quot = r_quo;
    assign o_stat = '{busy: r_busy, done: r_done};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DCNT_W'(DIVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DCNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            r_quo <= {r_quo[DIVD_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

### dv/set_sum_mean_median_test.sv
// Self-checking testbench for set_sum_mean_median: drives sets of signed samples,
// predicts each set's total, mean, doubled median, count and overflow flag, and
// compares them with the block's results. Depends on ssmm_pkg and the RTL top level.
`timescale 1ns / 1ps

module set_sum_mean_median_test;

    import ssmm_pkg::*;

    // Run length and guard figures: the sample budget for the random sets, the
    // quiet pause at the end and the cap on the whole run.
    localparam int          RAND_ITEMS = 1100;
    localparam int          TAIL_WAIT  = 200;
    localparam int unsigned CYCLE_CAP  = 1_000_000;

    // One result transaction, packed in the same order as the output tdata
    // (last field in the lowest bits).
    typedef struct packed {
        logic                 ovf;
        logic [OUT_CNT_W-1:0] cnt;
        logic [MED_W-1:0]     med2;
        logic [MEAN_W-1:0]    mean;
        logic [SUM_W-1:0]     total;
    } set_result_t;

    // One row of the directed table. Where typed is set, the row closes a set
    // and carries the result written out by hand.
    typedef struct {
        logic [SAMPLE_W-1:0] smp;
        bit                  last;
        bit                  typed;
        set_result_t         want;
    } dir_row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    // tdata: [15:0] sample (signed)
    logic [SAMPLE_W-1:0]    s_axis_tdata = '0;
    // tlast: final_item
    logic                   s_axis_tlast = 1'b0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata: [23:0] total_sum, [47:24] mean_q8, [64:48] median_times_two,
    //        [73:65] item_count, [74] overflowed, [79:75] zero
    wire [OUT_TDATA_W-1:0]  m_axis_tdata;

    set_sum_mean_median u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns period: six nanoseconds low, six high.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: the magnitudes of the current set in ascending order,
    // the saturating running sum and the flag for dropped samples.
    logic [MAG_W-1:0]  mag_store [$];
    logic [SUM_W-1:0]  run_sum = '0;
    bit                run_ovf = 1'b0;

    // Results predicted but not yet seen on the output, oldest first.
    set_result_t       pending_results [$];

    int                err_cnt = 0;
    int unsigned       cycle_cnt = 0;
    int                items_sent = 0;

    // Sender pacing: a burst of back-to-back transactions, then a gap.
    int                burst_left = 1;
    int                gap_left = 0;

    // Receiver pacing: a mode held for a random number of cycles.
    int                rdy_mode = 0;
    int                rdy_left = 0;

    dir_row_t          dir_tab [$];

    // Folds one accepted sample into the predictor. Returns 1 with the set's
    // result when the sample closes the set, after which the state is clear.
    function automatic bit fold_sample(input logic [SAMPLE_W-1:0] smp, input bit last,
                                       output set_result_t res);
        logic [MAG_W:0]   mag;
        logic [SUM_W:0]   acc;
        int               pos;
        int unsigned      n;
        longint unsigned  quot;

        res = '0;
        // Two's complement magnitude; the most negative sample gives 0x8000.
        mag = smp[SAMPLE_W-1] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
        if (mag_store.size() < MAX_ITEMS) begin
            // New magnitudes go after any equal ones already held.
            pos = mag_store.size();
            while (pos > 0 && mag_store[pos-1] > mag[MAG_W-1:0])
                pos--;
            mag_store.insert(pos, mag[MAG_W-1:0]);
            acc = {1'b0, run_sum} + {{(SUM_W+1-MAG_W-1){1'b0}}, mag};
            run_sum = acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
        end else begin
            run_ovf = 1'b1;
        end
        if (!last)
            return 1'b0;
        n = mag_store.size();
        res.total = run_sum;
        res.cnt   = n[OUT_CNT_W-1:0];
        res.ovf   = run_ovf;
        if (n > 0) begin
            quot = ({40'd0, run_sum} << 8) / n;
            res.mean = quot[MEAN_W-1:0];
            // For an odd count both indexes name the middle entry, for an even
            // count they name the two middle entries.
            res.med2 = {1'b0, mag_store[(n-1)/2]} + {1'b0, mag_store[n/2]};
        end
        mag_store.delete();
        run_sum = '0;
        run_ovf = 1'b0;
        return 1'b1;
    endfunction

    function automatic dir_row_t mk_row(input logic [SAMPLE_W-1:0] smp, input bit last,
                                        input bit typed, input int total, input int mean,
                                        input int med2, input int cnt, input bit ovf);
        dir_row_t r;

        r.smp        = smp;
        r.last       = last;
        r.typed      = typed;
        r.want.total = total[SUM_W-1:0];
        r.want.mean  = mean[MEAN_W-1:0];
        r.want.med2  = med2[MED_W-1:0];
        r.want.cnt   = cnt[OUT_CNT_W-1:0];
        r.want.ovf   = ovf;
        return r;
    endfunction

    // Picks a sample according to the value mode of the current set: full
    // random, the extremes only, a narrow band with many equal magnitudes, or
    // a fresh choice among those for every sample.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input int mode);
        int m;
        int v;

        m = (mode == 3) ? $urandom_range(0, 2) : mode;
        case (m)
            0: begin
                return SAMPLE_W'($urandom_range(0, 65535));
            end
            1: begin
                case ($urandom_range(0, 4))
                    0: return 16'h0000;
                    1: return 16'h0001;
                    2: return 16'hFFFF;
                    3: return 16'h7FFF;
                    default: return 16'h8000;
                endcase
            end
            default: begin
                v = $urandom_range(0, 16) - 8;
                return v[SAMPLE_W-1:0];
            end
        endcase
    endfunction

    // Offers one sample transaction and waits until it is accepted. A gap
    // chosen at the end of the previous burst is spent first with tvalid low.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit last,
                               input bit typed, input set_result_t want);
        set_result_t res;

        if (gap_left > 0) begin
            s_axis_tvalid <= 1'b0;
            while (gap_left > 0) begin
                @(posedge i_clk);
                gap_left--;
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        // The transaction has been taken at this edge.
        if (fold_sample(smp, last, res))
            pending_results.push_back(typed ? want : res);
        burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 5))
                0, 1: gap_left = 0;
                2:    gap_left = $urandom_range(20, 45);
                default: gap_left = $urandom_range(1, 6);
            endcase
        end
    endtask

    // Sends a whole set of random samples, the final one flagged last.
    task automatic send_set(input int len, input int mode);
        int k;

        for (k = 0; k < len; k++) begin
            send_sample(pick_sample(mode), k == len - 1, 1'b0, '0);
            if (k < MAX_ITEMS)
                items_sent++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // Receiver: ready always high, ready toggling at random, ready held low, or
    // a fixed two-in-three pattern, each mode held for a random stretch.
    always @(posedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = (rdy_mode == 2) ? $urandom_range(5, 40) : $urandom_range(10, 80);
        end
        rdy_left--;
        case (rdy_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= 1'b0;
            default: m_axis_tready <= (cycle_cnt % 3) != 0;
        endcase
    end

    // Result checker: every result transaction is matched against the oldest
    // prediction, field by field, including the zero padding above the fields.
    always @(posedge i_clk) begin
        set_result_t got;
        set_result_t want;

        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(set_result_t)-1:0];
            if (pending_results.size() == 0) begin
                $error("result transaction with no expected result waiting");
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                check_field("total_sum", 32'(want.total), 32'(got.total));
                check_field("mean_q8", 32'(want.mean), 32'(got.mean));
                check_field("median_times_two", 32'(want.med2), 32'(got.med2));
                check_field("item_count", 32'(want.cnt), 32'(got.cnt));
                check_field("overflowed", 32'(want.ovf), 32'(got.ovf));
                check_field("padding", 0,
                            32'(m_axis_tdata[OUT_TDATA_W-1:$bits(set_result_t)]));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int i;

        // Directed sets. The single-sample sets and the short sets whose
        // figures are obvious carry their results; the rest use the predictor.
        // Single zero sample.
        dir_tab.push_back(mk_row(16'h0000, 1, 1, 0, 0, 0, 1, 0));
        // Most negative sample on its own: magnitude 32768.
        dir_tab.push_back(mk_row(16'h8000, 1, 1, 32768, 8388608, 65536, 1, 0));
        // Most positive sample on its own.
        dir_tab.push_back(mk_row(16'h7FFF, 1, 1, 32767, 8388352, 65534, 1, 0));
        // Minus one gives magnitude one.
        dir_tab.push_back(mk_row(16'hFFFF, 1, 1, 1, 256, 2, 1, 0));
        // Two samples of mixed sign: the doubled median is the sum of their magnitudes.
        dir_tab.push_back(mk_row(16'd5, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(16'hFFFD, 1, 1, 8, 1024, 8, 2, 0));
        // Both extremes together.
        dir_tab.push_back(mk_row(16'h7FFF, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(16'h8000, 1, 1, 65535, 8388480, 65535, 2, 0));
        // Mean truncation: one third of 256, and a median of zero.
        dir_tab.push_back(mk_row(16'd1, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(16'd0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(16'd0, 1, 1, 1, 85, 0, 3, 0));
        // Odd set with equal magnitudes of both signs and both extremes.
        dir_tab.push_back(mk_row(16'd7, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(16'hFFF9, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(16'd7, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(16'h8000, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(16'h7FFF, 1, 0, 0, 0, 0, 0, 0));
        // Even set arriving in descending order.
        dir_tab.push_back(mk_row(16'd100, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(16'd50, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(16'hFFE7, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(16'd10, 1, 0, 0, 0, 0, 0, 0));
        // Zeros around the most negative sample.
        dir_tab.push_back(mk_row(16'd0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(16'h8000, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(16'd0, 1, 0, 0, 0, 0, 0, 0));

        // Reset is held low at the start and released once.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < dir_tab.size(); i++)
            send_sample(dir_tab[i].smp, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);

        // A set that exactly fills the store, then one that runs past it, so
        // that the flagged sample itself is dropped yet still yields a result.
        send_set(MAX_ITEMS, 0);
        send_set(MAX_ITEMS + $urandom_range(1, 8), 3);

        // Random sets, mostly short so that the divider phase comes often.
        while (items_sent < RAND_ITEMS) begin
            case ($urandom_range(0, 19))
                0:       send_set($urandom_range(41, 120), $urandom_range(0, 3));
                1, 2, 3,
                4:       send_set($urandom_range(9, 40), $urandom_range(0, 3));
                default: send_set($urandom_range(1, 8), $urandom_range(0, 3));
            endcase
        end
        s_axis_tvalid <= 1'b0;

        // Drain: every predicted result must arrive, then allow a quiet spell
        // in which any stray result transaction would still be caught.
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
rtl/ssmm_pkg.sv
rtl/ssmm_cell.sv
rtl/ssmm_div.sv
rtl/set_sum_mean_median.sv
dv/set_sum_mean_median_test.sv
